/* rtl/i2cmbe_pkg.sv */
// shared types and constants for the i2c master bit engine
// command codes, stream field layout and the per-command phase counts
// no dependencies
package i2cmbe_pkg;

    // function codes as they arrive on the input word
    localparam logic [2:0] FUNC_START = 3'd0;
    localparam logic [2:0] FUNC_STOP  = 3'd1;
    localparam logic [2:0] FUNC_SEND  = 3'd2;
    localparam logic [2:0] FUNC_RECV  = 3'd3;
    localparam logic [2:0] FUNC_SACK  = 3'd4;
    localparam logic [2:0] FUNC_RACK  = 3'd5;

    localparam logic [15:0] PHASE_TICKS_RESET = 16'd10;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    // active command, idle when no command runs
    typedef enum logic [2:0] {
        CMD_IDLE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_SEND  = 3'd3,
        CMD_RECV  = 3'd4,
        CMD_SACK  = 3'd5,
        CMD_RACK  = 3'd6
    } t_cmd;

    // number of pin phases in each command
    function automatic logic [4:0] phase_total(input t_cmd cmd);
        logic [4:0] total;
        case (cmd)
            CMD_START: total = 5'd4;
            CMD_STOP:  total = 5'd3;
            CMD_SEND:  total = 5'd24;
            CMD_RECV:  total = 5'd25;
            CMD_SACK:  total = 5'd3;
            CMD_RACK:  total = 5'd4;
            default:   total = 5'd0;
        endcase
        return total;
    endfunction

endpackage

/* rtl/i2c_master_bit_engine.sv */
// i2c master bit engine: one word in per timer tick, one word out per tick
// registered output word, valid in the cycle after its input word is accepted; one word per cycle while not stalled
// the output register frees the input side whenever it is empty or being taken
// synchronous active-low reset: idle, pins released, ack bit 1, phase ticks 10
// depends on i2cmbe_pkg
module i2c_master_bit_engine
    import i2cmbe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config write channel: phase_ticks
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [15:0]           i_cfg_data,
    // input words
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // cmd_valid, func[2:0], tx_data[7:0], ack_level, sda_in, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // output words
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // scl_out, sda_out, busy_res, done_res, rx_data[7:0], ack_received, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic [15:0] r_phase_ticks;
    t_cmd        r_cmd, n_cmd;
    logic [4:0]  r_idx, n_idx;
    logic [1:0]  r_sub, n_sub;   // bit slot position, phase index (-1 on recv) mod 3
    logic [15:0] r_tick, n_tick;
    logic [7:0]  r_shift, n_shift;
    logic        r_scl, n_scl;
    logic        r_sda, n_sda;
    logic        r_ack, n_ack;
    logic        r_busy, n_busy;
    logic [7:0]  r_rx, n_rx;
    logic        n_done;
    logic        apply;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic        in_accept;
    logic        in_cmd_valid;
    logic [2:0]  in_func;
    logic [7:0]  in_tx;
    logic        in_ack_level;
    logic        in_sda;
    logic [15:0] limit;
    logic [1:0]  sub_inc;

    assign in_cmd_valid = s_axis_tdata[0];
    assign in_func      = s_axis_tdata[3:1];
    assign in_tx        = s_axis_tdata[11:4];
    assign in_ack_level = s_axis_tdata[12];
    assign in_sda       = s_axis_tdata[13];

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign limit   = (r_phase_ticks == 16'd0) ? 16'd1 : r_phase_ticks;
    assign sub_inc = (r_sub == 2'd2) ? 2'd0 : r_sub + 2'd1;

    always_comb begin
        n_cmd   = r_cmd;
        n_idx   = r_idx;
        n_sub   = r_sub;
        n_tick  = r_tick;
        n_shift = r_shift;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_ack   = r_ack;
        n_busy  = r_busy;
        n_rx    = r_rx;
        n_done  = 1'b0;
        apply   = 1'b0;

        if (!r_busy) begin
            if (in_cmd_valid && (in_func <= FUNC_RACK)) begin
                n_cmd   = t_cmd'(in_func + 3'd1);
                n_idx   = 5'd0;
                n_sub   = 2'd0;
                n_tick  = 16'd1;
                n_busy  = 1'b1;
                n_shift = (in_func == FUNC_SEND) ? in_tx : 8'd0;
                apply   = 1'b1;
            end
        end else if (r_tick < limit) begin
            n_tick = r_tick + 16'd1;
        end else if (r_idx + 5'd1 >= phase_total(r_cmd)) begin
            if (r_cmd == CMD_RECV) begin
                n_rx = r_shift;
            end
            n_cmd  = CMD_IDLE;
            n_idx  = 5'd0;
            n_sub  = 2'd0;
            n_tick = 16'd0;
            n_busy = 1'b0;
            n_done = 1'b1;
        end else begin
            n_idx  = r_idx + 5'd1;
            n_tick = 16'd1;
            // receive byte has a leading release phase before its bit slots
            n_sub  = (r_cmd == CMD_RECV && r_idx == 5'd0) ? 2'd0 : sub_inc;
            apply  = 1'b1;
        end

        // pin action at the start of a phase
        if (apply) begin
            case (n_cmd)
                CMD_START: begin
                    case (n_idx)
                        5'd0:    n_sda = 1'b1;
                        5'd1:    n_scl = 1'b1;
                        5'd2:    n_sda = 1'b0;
                        default: n_scl = 1'b0;
                    endcase
                end
                CMD_STOP: begin
                    case (n_idx)
                        5'd0:    n_sda = 1'b0;
                        5'd1:    n_scl = 1'b1;
                        default: n_sda = 1'b1;
                    endcase
                end
                CMD_SEND: begin
                    case (n_sub)
                        2'd0: begin
                            n_sda   = n_shift[7];
                            n_shift = {n_shift[6:0], 1'b0};
                        end
                        2'd1:    n_scl = 1'b1;
                        default: n_scl = 1'b0;
                    endcase
                end
                CMD_RECV: begin
                    if (n_idx == 5'd0) begin
                        n_sda = 1'b1;
                    end else begin
                        case (n_sub)
                            2'd0:    n_scl = 1'b1;
                            2'd1:    n_shift = {n_shift[6:0], in_sda};
                            default: n_scl = 1'b0;
                        endcase
                    end
                end
                CMD_SACK: begin
                    case (n_idx)
                        5'd0:    n_sda = in_ack_level;
                        5'd1:    n_scl = 1'b1;
                        default: n_scl = 1'b0;
                    endcase
                end
                CMD_RACK: begin
                    case (n_idx)
                        5'd0:    n_sda = 1'b1;
                        5'd1:    n_scl = 1'b1;
                        5'd2:    n_ack = in_sda;
                        default: n_scl = 1'b0;
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RESET;
            r_cmd         <= CMD_IDLE;
            r_idx         <= 5'd0;
            r_sub         <= 2'd0;
            r_tick        <= 16'd0;
            r_shift       <= 8'd0;
            r_scl         <= 1'b1;
            r_sda         <= 1'b1;
            r_ack         <= 1'b1;
            r_busy        <= 1'b0;
            r_rx          <= 8'd0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_phase_ticks <= i_cfg_data;
            end
            if (in_accept) begin
                r_cmd   <= n_cmd;
                r_idx   <= n_idx;
                r_sub   <= n_sub;
                r_tick  <= n_tick;
                r_shift <= n_shift;
                r_scl   <= n_scl;
                r_sda   <= n_sda;
                r_ack   <= n_ack;
                r_busy  <= n_busy;
                r_rx    <= n_rx;
            end
            if (in_accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= {3'b000, n_ack, n_rx, n_done, n_busy, n_sda, n_scl};
        end
    end

endmodule

/* rtl/i2cmbe_checker.sv */
// port-level checks for the i2c master bit engine, bound to the top level
// depends on i2cmbe_pkg and i2c_master_bit_engine
module i2cmbe_checker
    import i2cmbe_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  i_s_tready,
    input logic                  i_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] i_m_tdata
);

    // a completed command leaves the engine idle in the same word
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && i_m_tdata[3]) |-> !i_m_tdata[2])
        else $error("done word still shows busy");

    // an empty output register never stalls the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_m_tvalid |-> i_s_tready)
        else $error("input stalled with empty output");

    // every accepted tick yields a word on the next cycle
    a_accept_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && i_s_tready) |=> i_m_tvalid)
        else $error("accepted tick produced no word");

    // a stalled word holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=> (i_m_tvalid && $stable(i_m_tdata)))
        else $error("stalled output word changed");

endmodule

bind i2c_master_bit_engine i2cmbe_checker u_i2cmbe_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);
